// File: sv/rsts_pkg.sv
// ----------------------------------------------------------------------------
// rsts_pkg: shared types for the two-key record sorter
// Item structs for both channels, the record held in each cell, the control
// word broadcast along the cell chain, and the operation and status codes.
// ----------------------------------------------------------------------------
package rsts_pkg;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_POP    = 1'b1;

   localparam logic [1:0] ST_INSERTED = 2'd0;
   localparam logic [1:0] ST_DROPPED  = 2'd1;
   localparam logic [1:0] ST_POPPED   = 2'd2;
   localparam logic [1:0] ST_EMPTY    = 2'd3;

   typedef struct packed {
      logic               operation;
      logic signed [31:0] group_number;
      logic signed [31:0] sequence_req;
      logic        [15:0] payload_tag;
   } req_type;

   typedef struct packed {
      logic        [1:0]  status;
      logic signed [31:0] out_group;
      logic signed [31:0] out_sequence;
      logic        [15:0] out_payload;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] group;
      logic signed [31:0] sequence_num;
      logic        [15:0] tag;
   } record_type;

   typedef struct packed {
      logic insert;
      logic pop;
   } cell_ctrl_type;

endpackage

// File: sv/record_sorter_two_key.sv
// ----------------------------------------------------------------------------
// record_sorter_two_key: sorted record store with a group/sequence key
// Output: the result of an item is registered and valid in the cycle after it is accepted.
// Throughput: one item per cycle; every cell compares and shifts in that cycle.
// Items stall only while a finished result waits on a stalled output.
// Reset clears every occupied bit; record contents are not reset.
// ----------------------------------------------------------------------------
module record_sorter_two_key #(
   parameter int unsigned CAPACITY = 64,
   parameter int unsigned TAG_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rsts_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsts_pkg::rsp_type rsp_data
);

   localparam int unsigned StoreBits = (TAG_BITS < 16) ? TAG_BITS : 16;
   localparam logic [16:0] TagFull   = (17'd1 << StoreBits) - 17'd1;
   localparam logic [15:0] TagMask   = TagFull[15:0];

   rsts_pkg::record_type    rec_vec   [CAPACITY];
   logic [CAPACITY-1:0]     occ_vec;
   logic [CAPACITY-1:0]     after_vec;
   rsts_pkg::record_type    new_rec;
   rsts_pkg::cell_ctrl_type ctrl;
   rsts_pkg::rsp_type       rsp_ff, rsp_in;
   logic                    rsp_valid_ff;
   logic                    accept, full, empty;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign full      = occ_vec[CAPACITY-1];
   assign empty     = !occ_vec[0];

   assign new_rec.group        = req_data.group_number;
   assign new_rec.sequence_num = req_data.sequence_req;
   assign new_rec.tag          = req_data.payload_tag & TagMask;

   assign ctrl.insert = accept && (req_data.operation == rsts_pkg::OP_INSERT) && !full;
   assign ctrl.pop    = accept && (req_data.operation == rsts_pkg::OP_POP) && !empty;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      rsts_pkg::record_type prev_rec, next_rec;
      logic                 prev_occ, prev_after, next_occ;

      if (i == 0) begin : g_head
         assign prev_rec   = new_rec;
         assign prev_occ   = 1'b1;
         assign prev_after = 1'b0;
      end else begin : g_body
         assign prev_rec   = rec_vec[i-1];
         assign prev_occ   = occ_vec[i-1];
         assign prev_after = after_vec[i-1];
      end

      if (i == CAPACITY-1) begin : g_tail
         assign next_rec = '0;
         assign next_occ = 1'b0;
      end else begin : g_link
         assign next_rec = rec_vec[i+1];
         assign next_occ = occ_vec[i+1];
      end

      rsts_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .new_rec    (new_rec),
         .prev_rec   (prev_rec),
         .prev_occ   (prev_occ),
         .prev_after (prev_after),
         .next_rec   (next_rec),
         .next_occ   (next_occ),
         .rec        (rec_vec[i]),
         .occ        (occ_vec[i]),
         .after      (after_vec[i])
      );
   end

   always_comb begin
      rsp_in = '0;
      if (req_data.operation == rsts_pkg::OP_INSERT) begin
         rsp_in.status = full ? rsts_pkg::ST_DROPPED : rsts_pkg::ST_INSERTED;
      end else if (empty) begin
         rsp_in.status = rsts_pkg::ST_EMPTY;
      end else begin
         rsp_in.status       = rsts_pkg::ST_POPPED;
         rsp_in.out_group    = rec_vec[0].group;
         rsp_in.out_sequence = rec_vec[0].sequence_num;
         rsp_in.out_payload  = rec_vec[0].tag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         rsp_valid_ff <= accept;
      end
   end

   // hold the result while the output is stalled
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_occ_prefix : assert property (@(posedge clock) disable iff (reset)
      ((occ_vec >> 1) & ~occ_vec) == '0)
      else $error("occupied cells are not a contiguous prefix");

   a_pop_result : assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.operation == rsts_pkg::OP_POP && !empty) |=>
      (rsp_valid_ff && rsp_ff.status == rsts_pkg::ST_POPPED))
      else $error("pop of a non-empty store did not report a record");

   a_drop_keeps : assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.operation == rsts_pkg::OP_INSERT && full) |=>
      $stable(occ_vec))
      else $error("dropped insert changed occupancy");

   a_zero_fields : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status != rsts_pkg::ST_POPPED) |->
      (rsp_ff.out_group == '0 && rsp_ff.out_sequence == '0 && rsp_ff.out_payload == '0))
      else $error("non-pop result carries record fields");
`endif

endmodule

// File: sv/rsts_cell.sv
// ----------------------------------------------------------------------------
// rsts_cell: one slot of the sorted chain
// Holds one record and its occupied bit. On insert it keeps its record, takes
// the new one, or takes its left neighbor's; on pop it takes its right
// neighbor's.
// ----------------------------------------------------------------------------
module rsts_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  rsts_pkg::cell_ctrl_type ctrl,
   input  rsts_pkg::record_type   new_rec,
   input  rsts_pkg::record_type   prev_rec,
   input  logic                   prev_occ,
   input  logic                   prev_after,
   input  rsts_pkg::record_type   next_rec,
   input  logic                   next_occ,
   output rsts_pkg::record_type   rec,
   output logic                   occ,
   output logic                   after
);

   rsts_pkg::record_type rec_ff, rec_in;
   logic                 occ_ff, occ_in;
   logic                 key_gt;

   // stored key strictly greater than the new key: equal keys stay ahead
   assign key_gt = ($signed(rec_ff.group) > $signed(new_rec.group)) ||
                   ((rec_ff.group == new_rec.group) &&
                    ($signed(rec_ff.sequence_num) > $signed(new_rec.sequence_num)));
   assign after  = occ_ff && key_gt;

   always_comb begin
      rec_in = rec_ff;
      occ_in = occ_ff;
      if (ctrl.pop) begin
         rec_in = next_rec;
         occ_in = next_occ;
      end else if (ctrl.insert) begin
         if (prev_after) begin
            rec_in = prev_rec;
         end else if (after || (!occ_ff && prev_occ)) begin
            rec_in = new_rec;
         end
         occ_in = occ_ff | prev_occ;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   assign rec = rec_ff;
   assign occ = occ_ff;

endmodule
